/* hdl/optical_mark_grid_reader_macros.svh */
// Assertion macros for the optical mark grid reader.
// Included by files that check their own logic; no other dependencies.
`ifndef OPTICAL_MARK_GRID_READER_MACROS_SVH
`define OPTICAL_MARK_GRID_READER_MACROS_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define OMGR_ASSERT_IMPLY(label, clk, rst, cond, impl, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (impl)) \
    else $error(msg);
// next-cycle implication
`define OMGR_ASSERT_NEXT(label, clk, rst, cond, impl, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (impl)) \
    else $error(msg);
`else
`define OMGR_ASSERT_IMPLY(label, clk, rst, cond, impl, msg)
`define OMGR_ASSERT_NEXT(label, clk, rst, cond, impl, msg)
`endif
`endif

/* hdl/omgr_pkg.sv */
// Shared types and constants of the optical mark grid reader.
// No dependencies; used by every module of the block except omgr_count_ram.
package omgr_pkg;

  // default sizes
  localparam int BOX_SIZE_DEF    = 10;
  localparam int MAX_GROUPS_DEF  = 32;
  localparam int MAX_CHOICES_DEF = 8;
  localparam int COORD_BITS_DEF  = 10;

  // register field widths
  localparam int CFG_W          = 10;
  localparam int REG_IDX_W      = 3;
  localparam int THR_W          = 9;
  localparam int CHOICE_CNT_W   = 4;
  localparam int GROUP_CNT_W    = 6;
  localparam int NG_W           = 7;   // holds an effective group count up to 64

  // box positions: origin + index * pitch, never wraps
  localparam int POS_W          = 17;

  // result field widths
  localparam int GROUP_IDX_W    = 5;
  localparam int CHOSEN_W       = 4;
  localparam int STATUS_W       = 2;

  // register indexes
  localparam logic [REG_IDX_W-1:0] REG_FIRST_X      = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_FIRST_Y      = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_CHOICE_PITCH = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_GROUP_PITCH  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_THRESHOLD    = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_CHOICE_COUNT = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_GROUP_COUNT  = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_ALONG_Y      = 3'd7;

  // mark status codes
  localparam logic [STATUS_W-1:0] MARK_NONE  = 2'd0;
  localparam logic [STATUS_W-1:0] MARK_ONE   = 2'd1;
  localparam logic [STATUS_W-1:0] MARK_MULTI = 2'd2;

  typedef struct packed {
    logic [CFG_W-1:0]        first_x;
    logic [CFG_W-1:0]        first_y;
    logic [CFG_W-1:0]        choice_pitch;
    logic [CFG_W-1:0]        group_pitch;
    logic [THR_W-1:0]        threshold;
    logic [CHOICE_CNT_W-1:0] choice_count;
    logic [GROUP_CNT_W-1:0]  group_count;
    logic                    choices_along_y;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    first_x:         10'd0,
    first_y:         10'd0,
    choice_pitch:    10'd24,
    group_pitch:     10'd24,
    threshold:       9'd50,
    choice_count:    4'd4,
    group_count:     6'd20,
    choices_along_y: 1'b0
  };

endpackage

/* hdl/omgr_box_match.sv */
// Box hit test: which choices contain a pixel, and which groups contain it when it is dark and in a choice box.
// Depends on omgr_pkg for the configuration struct and position width.
module omgr_box_match #(
  parameter int BOX_SIZE    = omgr_pkg::BOX_SIZE_DEF,
  parameter int MAX_GROUPS  = omgr_pkg::MAX_GROUPS_DEF,
  parameter int MAX_CHOICES = omgr_pkg::MAX_CHOICES_DEF,
  parameter int COORD_BITS  = omgr_pkg::COORD_BITS_DEF
) (
  input  logic [COORD_BITS-1:0] x,
  input  logic [COORD_BITS-1:0] y,
  input  logic                  dark,
  input  omgr_pkg::cfg_t        cfg,
  output logic [MAX_GROUPS-1:0]  group_hit,
  output logic [MAX_CHOICES-1:0] choice_hit
);

  localparam int PW = omgr_pkg::POS_W;

  logic [PW-1:0] c_coord, g_coord, c_org, g_org;
  logic [PW-1:0] c_start [MAX_CHOICES];
  logic [PW-1:0] g_start [MAX_GROUPS];
  logic          any_choice;

  // choices run along x unless choices_along_y is set
  assign c_coord = cfg.choices_along_y ? PW'(y) : PW'(x);
  assign g_coord = cfg.choices_along_y ? PW'(x) : PW'(y);
  assign c_org   = cfg.choices_along_y ? PW'(cfg.first_y) : PW'(cfg.first_x);
  assign g_org   = cfg.choices_along_y ? PW'(cfg.first_x) : PW'(cfg.first_y);

  for (genvar c = 0; c < MAX_CHOICES; c++) begin : g_choice
    assign c_start[c]    = c_org + PW'(c) * PW'(cfg.choice_pitch);
    assign choice_hit[c] = (omgr_pkg::CHOICE_CNT_W'(c) < cfg.choice_count) &&
                           (c_coord >= c_start[c]) &&
                           (c_coord < c_start[c] + PW'(BOX_SIZE));
  end

  assign any_choice = |choice_hit;

  for (genvar g = 0; g < MAX_GROUPS; g++) begin : g_group
    assign g_start[g]   = g_org + PW'(g) * PW'(cfg.group_pitch);
    assign group_hit[g] = dark && any_choice &&
                          (omgr_pkg::NG_W'(g) < omgr_pkg::NG_W'(cfg.group_count)) &&
                          (g_coord >= g_start[g]) &&
                          (g_coord < g_start[g] + PW'(BOX_SIZE));
  end

endmodule

/* hdl/omgr_count_ram.sv */
// Box count memory: one row of choice counts per group, registered read.
// Row valid flags give cleared rows; a read of the row written in the same
// cycle is forwarded. No package dependencies.
module omgr_count_ram #(
  parameter int ROWS  = 32,
  parameter int ROW_W = 56
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 clear,
  input  logic                                 rd_en,
  input  logic [((ROWS > 1) ? $clog2(ROWS) : 1)-1:0] rd_row,
  input  logic                                 wr_en,
  input  logic [((ROWS > 1) ? $clog2(ROWS) : 1)-1:0] wr_row,
  input  logic [ROW_W-1:0]                     wr_data,
  output logic [ROW_W-1:0]                     rd_data
);

  logic [ROW_W-1:0] mem [ROWS];
  logic [ROWS-1:0]  row_valid;
  logic [ROW_W-1:0] mem_q;
  logic [ROW_W-1:0] fwd_data;
  logic             vld_q;
  logic             fwd_q;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_row] <= wr_data;
    end
    if (rd_en) begin
      mem_q    <= mem[rd_row];
      fwd_data <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
      vld_q     <= 1'b0;
      fwd_q     <= 1'b0;
    end else begin
      if (clear) begin
        row_valid <= '0;
      end else if (wr_en) begin
        row_valid[wr_row] <= 1'b1;
      end
      if (rd_en) begin
        vld_q <= row_valid[rd_row];
        fwd_q <= wr_en && (wr_row == rd_row);
      end
    end
  end

  // rows never written since the last clear read as zero counts
  assign rd_data = fwd_q ? fwd_data : (vld_q ? mem_q : '0);

endmodule

/* hdl/omgr_row_judge.sv */
// Group verdict: compares one row of choice counts with the threshold.
// Depends on omgr_pkg for the configuration struct and status codes.
module omgr_row_judge #(
  parameter int BOX_SIZE    = omgr_pkg::BOX_SIZE_DEF,
  parameter int MAX_CHOICES = omgr_pkg::MAX_CHOICES_DEF
) (
  input  logic [MAX_CHOICES*$clog2(BOX_SIZE*BOX_SIZE+1)-1:0] row,
  input  omgr_pkg::cfg_t                    cfg,
  output logic [omgr_pkg::CHOSEN_W-1:0]     chosen,
  output logic [omgr_pkg::STATUS_W-1:0]     mark_status
);

  localparam int CNT_W = $clog2(BOX_SIZE * BOX_SIZE + 1);
  localparam int HIT_W = $clog2(MAX_CHOICES + 1);

  logic [MAX_CHOICES-1:0]        hit;
  logic [HIT_W-1:0]              hits;
  logic [omgr_pkg::CHOSEN_W-1:0] pick;

  for (genvar c = 0; c < MAX_CHOICES; c++) begin : g_hit
    assign hit[c] = (omgr_pkg::CHOICE_CNT_W'(c) < cfg.choice_count) &&
                    (omgr_pkg::THR_W'(row[c*CNT_W +: CNT_W]) >= cfg.threshold);
  end

  always_comb begin
    hits = '0;
    pick = '0;
    // walk down so the lowest filled choice wins
    for (int c = MAX_CHOICES - 1; c >= 0; c--) begin
      if (hit[c]) begin
        hits = hits + HIT_W'(1);
        pick = omgr_pkg::CHOSEN_W'(c + 1);
      end
    end
    if (hits == '0) begin
      mark_status = omgr_pkg::MARK_NONE;
    end else if (hits == HIT_W'(1)) begin
      mark_status = omgr_pkg::MARK_ONE;
    end else begin
      mark_status = omgr_pkg::MARK_MULTI;
    end
    chosen = (hits == HIT_W'(1)) ? pick : '0;
  end

endmodule

/* hdl/optical_mark_grid_reader.sv */
// Optical mark grid reader: counts dark pixels per mark box and reports
// one verdict word per group at the end of each image.
//
// Pixel channel: pixel_valid/pixel_stall with pixel_x, pixel_y, pixel_value
// and end_of_image. A pixel of value zero is dark and is counted in every
// box that holds it. Result channel: result_valid/result_stall carries
// group_index, chosen, mark_status and last_group, one word per group.
// Configuration is a write-only port (cfg_write, cfg_index, cfg_data),
// to be used between images.
// Throughput: one pixel per cycle in ST_RUN while each dark pixel lies in the
// boxes of at most one group; a dark pixel inside boxes of several groups
// stalls the pixel side for one read-modify-write of each group's count row
// in turn. The count RAM's single read port sets this limit.
// After end_of_image is taken the pixel side stalls; once pending updates
// drain (ST_FLUSH), each group's word comes from ST_RD (count row read), then
// ST_EV (verdict), which waits while result_stall holds the output register.
// Pixels are taken again after the last word is loaded; counts clear then.
// Reset restores register defaults and marks all count rows empty at once;
// there is no clearing pass.
`include "optical_mark_grid_reader_macros.svh"

module optical_mark_grid_reader #(
  parameter int BOX_SIZE    = omgr_pkg::BOX_SIZE_DEF,
  parameter int MAX_GROUPS  = omgr_pkg::MAX_GROUPS_DEF,
  parameter int MAX_CHOICES = omgr_pkg::MAX_CHOICES_DEF,
  parameter int COORD_BITS  = omgr_pkg::COORD_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [omgr_pkg::REG_IDX_W-1:0]      cfg_index,
  input  logic [omgr_pkg::CFG_W-1:0]          cfg_data,
  input  logic                                pixel_valid,
  output logic                                pixel_stall,
  input  logic [COORD_BITS-1:0]               pixel_x,
  input  logic [COORD_BITS-1:0]               pixel_y,
  input  logic [7:0]                          pixel_value,
  input  logic                                end_of_image,
  output logic                                result_valid,
  input  logic                                result_stall,
  output logic [omgr_pkg::GROUP_IDX_W-1:0]    group_index,
  output logic [omgr_pkg::CHOSEN_W-1:0]       chosen,
  output logic [omgr_pkg::STATUS_W-1:0]       mark_status,
  output logic                                last_group
);

  localparam int CNT_W = $clog2(BOX_SIZE * BOX_SIZE + 1);
  localparam int ROW_W = MAX_CHOICES * CNT_W;
  localparam int GRP_W = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
  localparam int NG_W  = omgr_pkg::NG_W;
  localparam logic [CNT_W-1:0] BOX_FULL = CNT_W'(BOX_SIZE * BOX_SIZE);

  typedef enum logic [1:0] {ST_RUN, ST_FLUSH, ST_RD, ST_EV} state_t;

  state_t         state;
  omgr_pkg::cfg_t cfg;

  // pixel stage
  logic                   s1_valid;
  logic [COORD_BITS-1:0]  s1_x, s1_y;
  logic                   s1_dark;
  // issue stage: groups still to update for the current pixel
  logic [MAX_GROUPS-1:0]  gmask;
  logic [MAX_CHOICES-1:0] cmask;
  // write-back stage
  logic                   wb_valid;
  logic [GRP_W-1:0]       wb_row;
  logic [MAX_CHOICES-1:0] wb_cmask;
  logic [GRP_W-1:0]       emit_group;

  logic [MAX_GROUPS-1:0]  match_group;
  logic [MAX_CHOICES-1:0] match_choice;
  logic [MAX_GROUPS-1:0]  lowbit;
  logic [GRP_W-1:0]       low_idx;
  logic                   s2_done, s1_move, pix_acc, pix_issue;
  logic                   rd_en, clear, flush_done, out_free, last_emit;
  logic [GRP_W-1:0]       rd_row;
  logic [ROW_W-1:0]       rd_data, wr_data;
  logic [NG_W-1:0]        eff_groups;
  logic [omgr_pkg::CHOSEN_W-1:0] judge_chosen;
  logic [omgr_pkg::STATUS_W-1:0] judge_status;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= omgr_pkg::CFG_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        omgr_pkg::REG_FIRST_X:      cfg.first_x         <= cfg_data;
        omgr_pkg::REG_FIRST_Y:      cfg.first_y         <= cfg_data;
        omgr_pkg::REG_CHOICE_PITCH: cfg.choice_pitch    <= cfg_data;
        omgr_pkg::REG_GROUP_PITCH:  cfg.group_pitch     <= cfg_data;
        omgr_pkg::REG_THRESHOLD:    cfg.threshold       <= cfg_data[omgr_pkg::THR_W-1:0];
        omgr_pkg::REG_CHOICE_COUNT: cfg.choice_count    <= cfg_data[omgr_pkg::CHOICE_CNT_W-1:0];
        omgr_pkg::REG_GROUP_COUNT:  cfg.group_count     <= cfg_data[omgr_pkg::GROUP_CNT_W-1:0];
        omgr_pkg::REG_ALONG_Y:      cfg.choices_along_y <= cfg_data[0];
        default: ;
      endcase
    end
  end

  omgr_box_match #(
    .BOX_SIZE(BOX_SIZE), .MAX_GROUPS(MAX_GROUPS),
    .MAX_CHOICES(MAX_CHOICES), .COORD_BITS(COORD_BITS)
  ) u_match (
    .x(s1_x), .y(s1_y), .dark(s1_dark), .cfg(cfg),
    .group_hit(match_group), .choice_hit(match_choice)
  );

  // a pixel leaves the issue stage once at most one group is left
  assign s2_done     = ((gmask & (gmask - MAX_GROUPS'(1))) == '0);
  assign pixel_stall = (state != ST_RUN) || (s1_valid && !s2_done);
  assign pix_acc     = pixel_valid && !pixel_stall;
  assign s1_move     = s1_valid && s2_done;
  assign pix_issue   = (gmask != '0);
  assign lowbit      = gmask & (~gmask + MAX_GROUPS'(1));

  always_comb begin
    low_idx = '0;
    for (int g = 0; g < MAX_GROUPS; g++) begin
      if (lowbit[g]) begin
        low_idx = low_idx | GRP_W'(g);
      end
    end
  end

  assign rd_en  = pix_issue || (state == ST_RD);
  assign rd_row = (state == ST_RD) ? emit_group : low_idx;

  // saturating increment of the hit choices in the row read last cycle
  for (genvar c = 0; c < MAX_CHOICES; c++) begin : g_inc
    assign wr_data[c*CNT_W +: CNT_W] =
      (wb_cmask[c] && (rd_data[c*CNT_W +: CNT_W] != BOX_FULL)) ?
        rd_data[c*CNT_W +: CNT_W] + CNT_W'(1) : rd_data[c*CNT_W +: CNT_W];
  end

  omgr_count_ram #(.ROWS(MAX_GROUPS), .ROW_W(ROW_W)) u_ram (
    .clk(clk), .rst(rst), .clear(clear),
    .rd_en(rd_en), .rd_row(rd_row),
    .wr_en(wb_valid), .wr_row(wb_row), .wr_data(wr_data),
    .rd_data(rd_data)
  );

  omgr_row_judge #(.BOX_SIZE(BOX_SIZE), .MAX_CHOICES(MAX_CHOICES)) u_judge (
    .row(rd_data), .cfg(cfg), .chosen(judge_chosen), .mark_status(judge_status)
  );

  assign eff_groups = (NG_W'(cfg.group_count) > NG_W'(MAX_GROUPS)) ?
                      NG_W'(MAX_GROUPS) : NG_W'(cfg.group_count);
  assign last_emit  = (NG_W'(emit_group) + NG_W'(1)) == eff_groups;
  assign out_free   = !result_valid || !result_stall;
  assign flush_done = !s1_valid && !pix_issue && !wb_valid;
  assign clear      = ((state == ST_FLUSH) && flush_done && (eff_groups == '0)) ||
                      ((state == ST_EV) && out_free && last_emit);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_RUN;
      s1_valid     <= 1'b0;
      gmask        <= '0;
      wb_valid     <= 1'b0;
      emit_group   <= '0;
      result_valid <= 1'b0;
    end else begin
      if (pix_acc) begin
        s1_valid <= 1'b1;
        s1_x     <= pixel_x;
        s1_y     <= pixel_y;
        s1_dark  <= (pixel_value == 8'd0);
      end else if (s1_move) begin
        s1_valid <= 1'b0;
      end

      if (s1_move) begin
        gmask <= match_group;
        cmask <= match_choice;
      end else begin
        gmask <= gmask & ~lowbit;
      end

      wb_valid <= pix_issue;
      wb_row   <= low_idx;
      wb_cmask <= cmask;

      // in ST_EV an accepted word is replaced by the next one below
      if (result_valid && !result_stall && (state != ST_EV)) begin
        result_valid <= 1'b0;
      end

      unique case (state)
        ST_RUN: begin
          if (pix_acc && end_of_image) begin
            state <= ST_FLUSH;
          end
        end
        ST_FLUSH: begin
          if (flush_done) begin
            emit_group <= '0;
            state      <= (eff_groups == '0) ? ST_RUN : ST_RD;
          end
        end
        ST_RD: begin
          state <= ST_EV;
        end
        ST_EV: begin
          if (out_free) begin
            result_valid <= 1'b1;
            group_index  <= omgr_pkg::GROUP_IDX_W'(emit_group);
            chosen       <= judge_chosen;
            mark_status  <= judge_status;
            last_group   <= last_emit;
            if (last_emit) begin
              emit_group <= '0;
              state      <= ST_RUN;
            end else begin
              emit_group <= emit_group + GRP_W'(1);
              state      <= ST_RD;
            end
          end
        end
        default: state <= ST_RUN;
      endcase
    end
  end

  `OMGR_ASSERT_IMPLY(a_run_burst_idle, clk, rst, state == ST_RUN, emit_group == '0, "burst position not reset")
  `OMGR_ASSERT_IMPLY(a_burst_drained, clk, rst, state == ST_RD, !wb_valid && gmask == '0 && !s1_valid, "burst read while pixel updates pending")
  `OMGR_ASSERT_IMPLY(a_chosen_status, clk, rst, result_valid, (mark_status == omgr_pkg::MARK_ONE) == (chosen != '0), "chosen disagrees with status")
  `OMGR_ASSERT_NEXT(a_eoi_flush, clk, rst, pixel_valid && !pixel_stall && end_of_image, state == ST_FLUSH, "end of image not followed by flush")

endmodule
